@@ design/rie_pkg.sv @@
// ----------------------------------------------------------------------------
// rie_pkg
// Shared types and codes for the integer execute stage.
// ----------------------------------------------------------------------------
package rie_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_DIVFIX,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        FLT_NONE     = 3'd0,
        FLT_OVF      = 3'd1,
        FLT_LOAD     = 3'd2,
        FLT_STORE    = 3'd3,
        FLT_SYSCALL  = 3'd4,
        FLT_BREAK    = 3'd5,
        FLT_RESERVED = 3'd6
    } fault_t;

    localparam logic [1:0] SOP_NONE = 2'd0;
    localparam logic [1:0] SOP_MTC0 = 2'd1;
    localparam logic [1:0] SOP_RFE  = 2'd2;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LWL     = 6'h22;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_LWR     = 6'h26;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SWL     = 6'h2a;
    localparam logic [5:0] OP_SW      = 6'h2b;
    localparam logic [5:0] OP_SWR     = 6'h2e;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0c;
    localparam logic [5:0] FN_BREAK   = 6'h0d;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1a;
    localparam logic [5:0] FN_DIVU    = 6'h1b;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2a;
    localparam logic [5:0] FN_SLTU    = 6'h2b;

    localparam logic [4:0] RS_MFC0 = 5'h00;
    localparam logic [4:0] RS_MTC0 = 5'h04;
    localparam logic [4:0] RS_RFE  = 5'h10;

    localparam logic [4:0] LINK_REG    = 5'd31;
    localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
    localparam int unsigned DIV_STEPS  = 32;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture item operands
        logic exec;      // run decode/execute into the result registers
        logic mul_step;  // one partial product step
        logic div_step;  // one restoring division step
        logic div_fix;   // signs and special cases into hi/lo
        logic clr_cnt;   // restart step counter
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic step_last;
    } dp_sts_t;

endpackage

@@ design/risc_integer_execute_stage.sv @@
// ----------------------------------------------------------------------------
// risc_integer_execute_stage
// MIPS-I integer execute: ALU, shifts, branches, loads/stores, cop0, HI/LO.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | instr src_a src_b cur_pc
//          |           |                      | load_word sys_reg_value
//  out     | output    | out_valid / out_ready| wb_* redirect target_pc store_*
//          |           |                      | mem_addr byte_mask fault_code sys_*
//
//  Ordinary instructions: capture, then execute into the result register;
//  a new item is taken in the cycle its predecessor's result is taken.
//  mult/multu and div/divu run one shift-add / restoring-subtract step
//  per cycle in the shared muldiv unit; div/divu add a sign fix-up step.
//  Reset clears the controller, HI and LO; payload registers are not reset.
//  A stalled result holds until out_ready; in_ready stays low meanwhile.
// ----------------------------------------------------------------------------
module risc_integer_execute_stage (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] instr,
    input  logic [31:0] src_a,
    input  logic [31:0] src_b,
    input  logic [31:0] cur_pc,
    input  logic [31:0] load_word,
    input  logic [31:0] sys_reg_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        wb_enable,
    output logic [4:0]  wb_index,
    output logic [31:0] wb_value,
    output logic        redirect,
    output logic [31:0] target_pc,
    output logic        store_enable,
    output logic [31:0] mem_addr,
    output logic [31:0] store_data,
    output logic [3:0]  byte_mask,
    output logic [2:0]  fault_code,
    output logic [1:0]  sys_op,
    output logic [4:0]  sys_index
);
    import rie_pkg::*;

    dp_cmd_t cmd;   // sequencer commands
    dp_sts_t sts;   // decode and step status back

    rie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rie_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .instr         (instr),
        .src_a         (src_a),
        .src_b         (src_b),
        .cur_pc        (cur_pc),
        .load_word     (load_word),
        .sys_reg_value (sys_reg_value),
        .wb_enable     (wb_enable),
        .wb_index      (wb_index),
        .wb_value      (wb_value),
        .redirect      (redirect),
        .target_pc     (target_pc),
        .store_enable  (store_enable),
        .mem_addr      (mem_addr),
        .store_data    (store_data),
        .byte_mask     (byte_mask),
        .fault_code    (fault_code),
        .sys_op        (sys_op),
        .sys_index     (sys_index)
    );

endmodule

@@ design/rie_ctrl.sv @@
// ----------------------------------------------------------------------------
// rie_ctrl
// Sequencer: accept, execute, multi-cycle multiply/divide, hand off result.
// ----------------------------------------------------------------------------
module rie_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output rie_pkg::dp_cmd_t  cmd,
    input  rie_pkg::dp_sts_t  sts
);
    import rie_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (sts.is_mul)      state_next = ST_MUL;
                else if (sts.is_div) state_next = ST_DIV;
                else                 state_next = ST_OUT;
            end
            ST_MUL:    if (sts.step_last) state_next = ST_OUT;
            ST_DIV:    if (sts.step_last) state_next = ST_DIVFIX;
            ST_DIVFIX: state_next = ST_OUT;
            ST_OUT:    if (out_ready) state_next = in_valid ? ST_EXEC : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec    = 1'b1;
                cmd.clr_cnt = 1'b1;
            end
            ST_MUL:    cmd.mul_step = 1'b1;
            ST_DIV:    cmd.div_step = 1'b1;
            ST_DIVFIX: cmd.div_fix  = 1'b1;
            ST_OUT:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
                cmd.load  = out_ready && in_valid;
            end
            default: ;
        endcase
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_DIV) |-> !in_ready)
        else $error("item taken during multiply/divide");
    a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_EXEC)
        else $error("load not followed by execute");

endmodule

@@ design/rie_datapath.sv @@
// ----------------------------------------------------------------------------
// rie_datapath
// Operand registers, decode/execute logic, HI/LO and the muldiv unit.
// ----------------------------------------------------------------------------
module rie_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  rie_pkg::dp_cmd_t  cmd,
    output rie_pkg::dp_sts_t  sts,
    input  logic [31:0]       instr,
    input  logic [31:0]       src_a,
    input  logic [31:0]       src_b,
    input  logic [31:0]       cur_pc,
    input  logic [31:0]       load_word,
    input  logic [31:0]       sys_reg_value,
    output logic              wb_enable,
    output logic [4:0]        wb_index,
    output logic [31:0]       wb_value,
    output logic              redirect,
    output logic [31:0]       target_pc,
    output logic              store_enable,
    output logic [31:0]       mem_addr,
    output logic [31:0]       store_data,
    output logic [3:0]        byte_mask,
    output logic [2:0]        fault_code,
    output logic [1:0]        sys_op,
    output logic [4:0]        sys_index
);
    import rie_pkg::*;

    // captured item
    logic [31:0] ins_reg, a_reg, b_reg, pc_reg, mw_reg, cv_reg;
    logic [31:0] hi_reg, hi_next, lo_reg, lo_next;

    // muldiv working registers
    logic [31:0] mcand_reg, mcand_next;    // multiplicand / divisor magnitude
    logic [31:0] mplr_reg, mplr_next;      // multiplier / quotient shift reg
    logic [32:0] acc_reg, acc_next;        // partial product high / remainder
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_q_reg, neg_q_next, neg_r_reg, neg_r_next;
    logic        div_zero_reg, div_zero_next;

    // result registers
    logic        wen_r, redir_r, sen_r;
    logic [4:0]  widx_r, sidx_r;
    logic [31:0] wval_r, tgt_r, addr_r, sdata_r;
    logic [3:0]  mask_r;
    logic [2:0]  fault_r;
    logic [1:0]  sop_r;

    // combinational execute
    logic        wen, redir, sen, is_mem, is_mul, is_div, m_sgn, d_sgn;
    logic        wr_hi, wr_lo;
    logic [4:0]  widx, sidx;
    logic [31:0] wval, tgt, sdata;
    logic [3:0]  mask;
    fault_t      fault;
    logic [1:0]  sop;

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh, vsh;
    logic [15:0] imm;
    logic [31:0] simm, link, btgt, ea, sum, diff, addi_r;
    logic [1:0]  lane;

    assign op   = ins_reg[31:26];
    assign rs   = ins_reg[25:21];
    assign rt   = ins_reg[20:16];
    assign rd   = ins_reg[15:11];
    assign sh   = ins_reg[10:6];
    assign fn   = ins_reg[5:0];
    assign imm  = ins_reg[15:0];
    assign simm = {{16{imm[15]}}, imm};
    assign vsh  = a_reg[4:0];
    assign link = pc_reg + 32'd8;
    assign btgt = pc_reg + 32'd4 + {simm[29:0], 2'b00};
    assign ea   = a_reg + simm;
    assign lane = ea[1:0];
    assign sum  = a_reg + b_reg;
    assign diff = a_reg - b_reg;
    assign addi_r = ea;

    always_comb
    begin
        wen = 1'b0; redir = 1'b0; sen = 1'b0; is_mem = 1'b0;
        is_mul = 1'b0; is_div = 1'b0; m_sgn = 1'b0; d_sgn = 1'b0;
        wr_hi = 1'b0; wr_lo = 1'b0;
        widx = '0; sidx = '0; wval = '0; tgt = '0; sdata = '0; mask = '0;
        fault = FLT_NONE; sop = SOP_NONE;
        if (op == OP_SPECIAL)
        begin
            unique case (fn)
                FN_SLL:  begin wen = 1'b1; widx = rd; wval = b_reg << sh; end
                FN_SRL:  begin wen = 1'b1; widx = rd; wval = b_reg >> sh; end
                FN_SRA:  begin wen = 1'b1; widx = rd; wval = $signed(b_reg) >>> sh; end
                FN_SLLV: begin wen = 1'b1; widx = rd; wval = b_reg << vsh; end
                FN_SRLV: begin wen = 1'b1; widx = rd; wval = b_reg >> vsh; end
                FN_SRAV: begin wen = 1'b1; widx = rd; wval = $signed(b_reg) >>> vsh; end
                FN_JR:   begin redir = 1'b1; tgt = a_reg; end
                FN_JALR:
                begin
                    redir = 1'b1; tgt = a_reg; wen = 1'b1; widx = rd; wval = link;
                end
                FN_SYSCALL: fault = FLT_SYSCALL;
                FN_BREAK:   fault = FLT_BREAK;
                FN_MFHI: begin wen = 1'b1; widx = rd; wval = hi_reg; end
                FN_MTHI: wr_hi = 1'b1;
                FN_MFLO: begin wen = 1'b1; widx = rd; wval = lo_reg; end
                FN_MTLO: wr_lo = 1'b1;
                FN_MULT:  begin is_mul = 1'b1; m_sgn = 1'b1; end
                FN_MULTU: is_mul = 1'b1;
                FN_DIV:   begin is_div = 1'b1; d_sgn = 1'b1; end
                FN_DIVU:  is_div = 1'b1;
                FN_ADD:
                begin
                    if ((~(a_reg[31] ^ b_reg[31])) & (a_reg[31] ^ sum[31])) fault = FLT_OVF;
                    else begin wen = 1'b1; widx = rd; wval = sum; end
                end
                FN_ADDU: begin wen = 1'b1; widx = rd; wval = sum; end
                FN_SUB:
                begin
                    if ((a_reg[31] ^ b_reg[31]) & (a_reg[31] ^ diff[31])) fault = FLT_OVF;
                    else begin wen = 1'b1; widx = rd; wval = diff; end
                end
                FN_SUBU: begin wen = 1'b1; widx = rd; wval = diff; end
                FN_AND:  begin wen = 1'b1; widx = rd; wval = a_reg & b_reg; end
                FN_OR:   begin wen = 1'b1; widx = rd; wval = a_reg | b_reg; end
                FN_XOR:  begin wen = 1'b1; widx = rd; wval = a_reg ^ b_reg; end
                FN_NOR:  begin wen = 1'b1; widx = rd; wval = ~(a_reg | b_reg); end
                FN_SLT:
                begin
                    wen = 1'b1; widx = rd;
                    wval = {31'd0, $signed(a_reg) < $signed(b_reg)};
                end
                FN_SLTU: begin wen = 1'b1; widx = rd; wval = {31'd0, a_reg < b_reg}; end
                default: fault = FLT_RESERVED;
            endcase
        end
        else
        begin
            unique case (op)
                OP_REGIMM:
                begin
                    if (rt[4:1] == 4'b1000) begin wen = 1'b1; widx = LINK_REG; wval = link; end
                    if (rt[0] ^ a_reg[31]) begin redir = 1'b1; tgt = btgt; end
                end
                OP_J, OP_JAL:
                begin
                    redir = 1'b1;
                    tgt   = {link[31:28] - 4'd0 & 4'hf, ins_reg[25:0], 2'b00};
                    tgt[31:28] = (pc_reg[31:28] + {3'd0, &pc_reg[27:2]});
                    if (op == OP_JAL) begin wen = 1'b1; widx = LINK_REG; wval = link; end
                end
                OP_BEQ:  if (a_reg == b_reg) begin redir = 1'b1; tgt = btgt; end
                OP_BNE:  if (a_reg != b_reg) begin redir = 1'b1; tgt = btgt; end
                OP_BLEZ:
                    if (a_reg[31] || a_reg == '0) begin redir = 1'b1; tgt = btgt; end
                OP_BGTZ:
                    if (!a_reg[31] && a_reg != '0) begin redir = 1'b1; tgt = btgt; end
                OP_ADDI:
                begin
                    if ((~(a_reg[31] ^ simm[31])) & (a_reg[31] ^ addi_r[31])) fault = FLT_OVF;
                    else begin wen = 1'b1; widx = rt; wval = addi_r; end
                end
                OP_ADDIU: begin wen = 1'b1; widx = rt; wval = addi_r; end
                OP_SLTI:
                begin
                    wen = 1'b1; widx = rt;
                    wval = {31'd0, $signed(a_reg) < $signed(simm)};
                end
                OP_SLTIU: begin wen = 1'b1; widx = rt; wval = {31'd0, a_reg < simm}; end
                OP_ANDI: begin wen = 1'b1; widx = rt; wval = a_reg & {16'd0, imm}; end
                OP_ORI:  begin wen = 1'b1; widx = rt; wval = a_reg | {16'd0, imm}; end
                OP_XORI: begin wen = 1'b1; widx = rt; wval = a_reg ^ {16'd0, imm}; end
                OP_LUI:  begin wen = 1'b1; widx = rt; wval = {imm, 16'd0}; end
                OP_COP0:
                begin
                    if (rs == RS_MFC0)
                    begin
                        wen = 1'b1; widx = rt; wval = cv_reg; sidx = rd;
                    end
                    else if (rs == RS_MTC0)
                    begin
                        sop = SOP_MTC0; sidx = rd; sdata = b_reg;
                    end
                    else if (rs == RS_RFE) sop = SOP_RFE;
                    else fault = FLT_RESERVED;
                end
                OP_LB, OP_LBU:
                begin
                    is_mem = 1'b1; wen = 1'b1; widx = rt;
                    wval = {24'd0, 8'(mw_reg >> {lane, 3'b000})};
                    if (op == OP_LB) wval[31:8] = {24{wval[7]}};
                end
                OP_LH, OP_LHU:
                begin
                    is_mem = 1'b1;
                    if (ea[0]) fault = FLT_LOAD;
                    else
                    begin
                        wen = 1'b1; widx = rt;
                        wval = {16'd0, lane[1] ? mw_reg[31:16] : mw_reg[15:0]};
                        if (op == OP_LH) wval[31:16] = {16{wval[15]}};
                    end
                end
                OP_LW:
                begin
                    is_mem = 1'b1;
                    if (lane != 2'd0) fault = FLT_LOAD;
                    else begin wen = 1'b1; widx = rt; wval = mw_reg; end
                end
                OP_LWL:
                begin
                    is_mem = 1'b1; wen = 1'b1; widx = rt;
                    case (lane)
                        2'd0:    wval = {mw_reg[7:0], b_reg[23:0]};
                        2'd1:    wval = {mw_reg[15:0], b_reg[15:0]};
                        2'd2:    wval = {mw_reg[23:0], b_reg[7:0]};
                        default: wval = mw_reg;
                    endcase
                end
                OP_LWR:
                begin
                    is_mem = 1'b1; wen = 1'b1; widx = rt;
                    case (lane)
                        2'd0:    wval = mw_reg;
                        2'd1:    wval = {b_reg[31:24], mw_reg[31:8]};
                        2'd2:    wval = {b_reg[31:16], mw_reg[31:16]};
                        default: wval = {b_reg[31:8], mw_reg[31:24]};
                    endcase
                end
                OP_SB:
                begin
                    is_mem = 1'b1; sen = 1'b1;
                    sdata = b_reg << {lane, 3'b000}; mask = 4'b0001 << lane;
                end
                OP_SH:
                begin
                    is_mem = 1'b1;
                    if (ea[0]) fault = FLT_STORE;
                    else
                    begin
                        sen = 1'b1;
                        sdata = lane[1] ? {b_reg[15:0], 16'd0} : b_reg;
                        mask  = lane[1] ? 4'b1100 : 4'b0011;
                    end
                end
                OP_SW:
                begin
                    is_mem = 1'b1;
                    if (lane != 2'd0) fault = FLT_STORE;
                    else begin sen = 1'b1; sdata = b_reg; mask = 4'b1111; end
                end
                OP_SWL:
                begin
                    is_mem = 1'b1; sen = 1'b1;
                    sdata = b_reg >> {~lane, 3'b000}; mask = 4'b1111 >> (~lane);
                end
                OP_SWR:
                begin
                    is_mem = 1'b1; sen = 1'b1;
                    sdata = b_reg << {lane, 3'b000}; mask = 4'b1111 << lane;
                end
                default: fault = FLT_RESERVED;
            endcase
        end
        if (!wen || widx == '0)
        begin
            wen = 1'b0; widx = '0; wval = '0;
        end
        if (!sen) mask = '0;
    end

    assign sts.is_mul    = is_mul;
    assign sts.is_div    = is_div;
    assign sts.step_last = (cnt_reg == 5'(DIV_STEPS - 1));

    // ---- muldiv ----
    logic [31:0] a_mag, b_mag;
    logic [32:0] add_r, sub_r, shl, mul_sum;
    logic [31:0] q_fix, r_fix;

    assign a_mag = (d_sgn && a_reg[31]) ? (~a_reg + 32'd1) : a_reg;
    assign b_mag = (d_sgn && b_reg[31]) ? (~b_reg + 32'd1) : b_reg;

    // multiply: shift-add, 33-bit accumulator with sign handling per step
    // divide: restoring, remainder in acc, quotient shifted into mplr
    assign add_r = acc_reg + (mplr_reg[0] ? {neg_q_reg & mcand_reg[31], mcand_reg} : 33'd0);
    assign shl   = {acc_reg[31:0], mplr_reg[31]};
    assign sub_r = shl - {1'b0, mcand_reg};
    assign q_fix = neg_q_reg ? (~mplr_reg + 32'd1) : mplr_reg;
    assign r_fix = neg_r_reg ? (~acc_reg[31:0] + 32'd1) : acc_reg[31:0];

    // last step of signed multiply subtracts instead of adds
    assign mul_sum = (neg_q_reg && sts.step_last && mplr_reg[0])
                     ? (acc_reg - {mcand_reg[31], mcand_reg}) : add_r;

    always_comb
    begin
        mcand_next = mcand_reg; mplr_next = mplr_reg; acc_next = acc_reg;
        cnt_next = cnt_reg; neg_q_next = neg_q_reg; neg_r_next = neg_r_reg;
        div_zero_next = div_zero_reg;
        hi_next = hi_reg; lo_next = lo_reg;
        if (cmd.clr_cnt) cnt_next = '0;
        else if (cmd.mul_step || cmd.div_step) cnt_next = cnt_reg + 5'd1;
        if (cmd.exec)
        begin
            if (wr_hi) hi_next = a_reg;
            if (wr_lo) lo_next = a_reg;
            acc_next = '0;
            if (is_mul)
            begin
                // signed: multiplicand sign-extended, last step subtracts
                mcand_next = a_reg;
                mplr_next  = b_reg;
                neg_q_next = m_sgn;    // reused as "signed multiply"
            end
            else
            begin
                mcand_next   = b_mag;
                mplr_next    = a_mag;
                neg_q_next   = d_sgn && (a_reg[31] ^ b_reg[31]);
                neg_r_next   = d_sgn && a_reg[31];
                div_zero_next = (b_reg == '0);
            end
        end
        if (cmd.mul_step)
        begin
            // unsigned keeps the carry as a magnitude bit, signed shifts arithmetically
            acc_next  = {neg_q_reg & mul_sum[32], mul_sum[32:1]};
            mplr_next = {mul_sum[0], mplr_reg[31:1]};
            if (sts.step_last)
            begin
                hi_next = mul_sum[32:1];
                lo_next = {mul_sum[0], mplr_reg[31:1]};
            end
        end
        if (cmd.div_step)
        begin
            if (!sub_r[32])
            begin
                acc_next  = {1'b0, sub_r[31:0]};
                mplr_next = {mplr_reg[30:0], 1'b1};
            end
            else
            begin
                acc_next  = shl;
                mplr_next = {mplr_reg[30:0], 1'b0};
            end
        end
        if (cmd.div_fix)
        begin
            if (div_zero_reg)
            begin
                // remainder already holds dividend magnitude; use original
                hi_next = a_reg;
                lo_next = (neg_r_reg) ? 32'd1 : 32'hffff_ffff;
            end
            else
            begin
                hi_next = r_fix;
                lo_next = q_fix;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg <= '0;
            lo_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next; mplr_reg <= mplr_next; acc_reg <= acc_next;
        neg_q_reg <= neg_q_next; neg_r_reg <= neg_r_next;
        div_zero_reg <= div_zero_next;
        if (cmd.load)
        begin
            ins_reg <= instr; a_reg <= src_a; b_reg <= src_b;
            pc_reg <= cur_pc; mw_reg <= load_word; cv_reg <= sys_reg_value;
        end
        if (cmd.exec)
        begin
            wen_r <= wen; widx_r <= widx; wval_r <= wval;
            redir_r <= redir; tgt_r <= tgt;
            sen_r <= sen; addr_r <= is_mem ? {ea[31:2], 2'b00} : 32'd0;
            sdata_r <= sdata; mask_r <= mask;
            fault_r <= fault; sop_r <= sop; sidx_r <= sidx;
        end
    end

    assign wb_enable    = wen_r;
    assign wb_index     = widx_r;
    assign wb_value     = wval_r;
    assign redirect     = redir_r;
    assign target_pc    = tgt_r;
    assign store_enable = sen_r;
    assign mem_addr     = addr_r;
    assign store_data   = sdata_r;
    assign byte_mask    = mask_r;
    assign fault_code   = fault_r;
    assign sys_op       = sop_r;
    assign sys_index    = sidx_r;

    a_zero_wb: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.exec) |-> !(wb_enable && wb_index == '0))
        else $error("writeback to register zero");
    a_fault_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.exec) && fault_code != FLT_NONE |-> !wb_enable && !store_enable)
        else $error("side effect with fault");
    a_mask_store: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.exec) |-> (byte_mask != '0) == store_enable)
        else $error("byte mask without store");

endmodule
